@@ hdl/double_hash_context_matcher_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the context matcher
// Shared shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_HASH_CONTEXT_MATCHER_DEFINES_SVH
`define DOUBLE_HASH_CONTEXT_MATCHER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DHCM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DHCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/dhcm_pkg.sv @@
// ----------------------------------------------------------------------------
// Context matcher package
// Request and register codes, register reset values, controller states and the result record.
// ----------------------------------------------------------------------------
package dhcm_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [2:0] CFG_TABLE_SIZE    = 3'd0;
    localparam logic [2:0] CFG_KEY_MASK      = 3'd1;
    localparam logic [2:0] CFG_MIN_SHARED    = 3'd2;
    localparam logic [2:0] CFG_JACCARD_FLOOR = 3'd3;
    localparam logic [2:0] CFG_MAX_DISTANCE  = 3'd4;
    localparam logic [2:0] CFG_UNREL_DIST    = 3'd5;

    localparam logic [16:0] RST_TABLE_SIZE    = 17'd65536;
    localparam logic [63:0] RST_KEY_MASK      = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] RST_MIN_SHARED    = 32'd10000;
    localparam logic [15:0] RST_JACCARD_FLOOR = 16'd5243;
    localparam logic [15:0] RST_MAX_DISTANCE  = 16'd5898;
    localparam logic [15:0] RST_UNREL_DIST    = 16'd32768;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_RD,
        ST_CHK,
        ST_FIN_UNI,
        ST_FIN_MUL,
        ST_DIV,
        ST_FIN_END,
        ST_RESULT
    } dhcm_state_t;

    typedef struct packed {
        logic [15:0] distance_q16;
        logic        related;
        logic [31:0] differ_count;
        logic [31:0] shared_count;
        logic        table_full;
        logic        object_differs;
        logic        matched;
    } dhcm_result_t;

endpackage

@@ hdl/double_hash_context_matcher.sv @@
// ----------------------------------------------------------------------------
// Double hash context matcher
// Open-addressing slot table with double hashing, query counting and a
// relatedness verdict with a Q0.16 distance.
// ----------------------------------------------------------------------------
// The slot table is one single-port-write, registered-read memory of
// TABLE_DEPTH 64-bit entries. After reset, and for every clear request, the
// block sweeps the whole memory one entry per cycle and accepts no
// transaction meanwhile. Insert and query first reduce the masked key
// modulo T and T-1 one bit per cycle, then read and check each probed slot
// in turn (memory read, then check) and hand over the result. Finish works
// out the distance with a bit-serial 48-bit division. One transaction is
// worked on at a time; the next is accepted as soon as the previous result
// sits in the output register.
`include "double_hash_context_matcher_defines.svh"

module double_hash_context_matcher #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // tuple
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    // matched, object_differs, table_full, shared_count[31:0],
    // differ_count[31:0], related, distance_q16[15:0], zero fill
    output logic [87:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int TW = AW + 1;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // Configuration registers
    logic [16:0] table_size_reg;
    logic [63:0] key_mask_reg;
    logic [31:0] min_shared_reg;
    logic [15:0] jaccard_floor_reg;
    logic [15:0] max_distance_reg;
    logic [15:0] unrel_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg    <= dhcm_pkg::RST_TABLE_SIZE;
            key_mask_reg      <= dhcm_pkg::RST_KEY_MASK;
            min_shared_reg    <= dhcm_pkg::RST_MIN_SHARED;
            jaccard_floor_reg <= dhcm_pkg::RST_JACCARD_FLOOR;
            max_distance_reg  <= dhcm_pkg::RST_MAX_DISTANCE;
            unrel_dist_reg    <= dhcm_pkg::RST_UNREL_DIST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dhcm_pkg::CFG_TABLE_SIZE:    table_size_reg    <= cfg_data[16:0];
                dhcm_pkg::CFG_KEY_MASK:      key_mask_reg      <= cfg_data;
                dhcm_pkg::CFG_MIN_SHARED:    min_shared_reg    <= cfg_data[31:0];
                dhcm_pkg::CFG_JACCARD_FLOOR: jaccard_floor_reg <= cfg_data[15:0];
                dhcm_pkg::CFG_MAX_DISTANCE:  max_distance_reg  <= cfg_data[15:0];
                dhcm_pkg::CFG_UNREL_DIST:    unrel_dist_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Slots in use, clamped to the table.
    logic [TW-1:0] t_eff;
    logic [TW-1:0] t_m1;

    always_comb
    begin
        if (table_size_reg < 17'd2)
            t_eff = TW'(2);
        else if (32'(table_size_reg) > 32'(TABLE_DEPTH))
            t_eff = TW'(TABLE_DEPTH);
        else
            t_eff = TW'(table_size_reg);
    end

    assign t_m1 = t_eff - TW'(1);

    // Control and datapath registers
    dhcm_pkg::dhcm_state_t state_reg, state_next;
    logic [TW-1:0] idx_reg, idx_next;
    logic [TW-1:0] step_reg, step_next;
    logic [TW-1:0] probe_cnt_reg, probe_cnt_next;
    logic [TW-1:0] rem_a_reg, rem_a_next;
    logic [TW-1:0] rem_b_reg, rem_b_next;
    logic [31:0]   rem_d_reg, rem_d_next;
    logic [63:0]   shreg_reg, shreg_next;
    logic [5:0]    bit_cnt_reg, bit_cnt_next;
    logic [TW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          clr_req_reg, clr_req_next;
    logic [1:0]    req_reg, req_next;
    logic [63:0]   tuple_reg, tuple_next;
    logic [63:0]   key_reg, key_next;
    logic [32:0]   uni_reg, uni_next;
    logic [48:0]   prod_j_reg, prod_j_next;
    logic [47:0]   prod_d_reg, prod_d_next;
    logic [31:0]   ref_cnt_reg, ref_cnt_next;
    logic [31:0]   qry_cnt_reg, qry_cnt_next;
    logic [31:0]   shared_reg, shared_next;
    logic [31:0]   differ_reg, differ_next;
    dhcm_pkg::dhcm_result_t res_reg, res_next;
    dhcm_pkg::dhcm_result_t out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    // Slot memory
    logic [63:0]   slot_mem [TABLE_DEPTH];
    logic [63:0]   rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [63:0]   mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= slot_mem[idx_reg[AW-1:0]];
    end

    // One step of the bit-serial remainders for both hash moduli.
    logic [TW:0]   ra_sh, rb_sh;
    logic [TW-1:0] ra_new, rb_new;
    assign ra_sh  = {rem_a_reg, shreg_reg[63]};
    assign rb_sh  = {rem_b_reg, shreg_reg[63]};
    assign ra_new = (ra_sh >= {1'b0, t_eff}) ? TW'(ra_sh - {1'b0, t_eff}) : ra_sh[TW-1:0];
    assign rb_new = (rb_sh >= {1'b0, t_m1}) ? TW'(rb_sh - {1'b0, t_m1}) : rb_sh[TW-1:0];

    // Next probe index, wrapped once since both terms are below T.
    logic [TW:0]   idx_sum;
    logic [TW-1:0] idx_wrap;
    assign idx_sum  = {1'b0, idx_reg} + {1'b0, step_reg};
    assign idx_wrap = (idx_sum >= {1'b0, t_eff}) ? TW'(idx_sum - {1'b0, t_eff})
                                                 : idx_sum[TW-1:0];

    // One step of the restoring division for the distance.
    logic [32:0] rd_sh;
    logic [32:0] rd_diff;
    logic        rd_ge;
    assign rd_sh   = {rem_d_reg, shreg_reg[63]};
    assign rd_diff = rd_sh - {1'b0, shared_reg};
    assign rd_ge   = (rd_sh >= {1'b0, shared_reg});

    // Finish verdict
    logic [32:0] both_sum;
    logic [47:0] quotient;
    logic        test_shared, test_jaccard, test_dist;
    assign both_sum     = {1'b0, ref_cnt_reg} + {1'b0, qry_cnt_reg};
    assign quotient     = shreg_reg[47:0];
    assign test_shared  = shared_reg > min_shared_reg;
    assign test_jaccard = {1'b0, shared_reg, 16'd0} > prod_j_reg;
    assign test_dist    = {differ_reg, 16'd0} < prod_d_reg;

    logic          slot_empty, slot_hit;
    assign slot_empty = (rd_data_reg == 64'd0);
    assign slot_hit   = ((rd_data_reg & key_mask_reg) == key_reg);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        probe_cnt_next = probe_cnt_reg;
        rem_a_next     = rem_a_reg;
        rem_b_next     = rem_b_reg;
        rem_d_next     = rem_d_reg;
        shreg_next     = shreg_reg;
        bit_cnt_next   = bit_cnt_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_req_next   = clr_req_reg;
        req_next       = req_reg;
        tuple_next     = tuple_reg;
        key_next       = key_reg;
        uni_next       = uni_reg;
        prod_j_next    = prod_j_reg;
        prod_d_next    = prod_d_reg;
        ref_cnt_next   = ref_cnt_reg;
        qry_cnt_next   = qry_cnt_reg;
        shared_next    = shared_reg;
        differ_next    = differ_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[AW-1:0];
        mem_wdata      = tuple_reg;
        s_tready       = 1'b0;

        case (state_reg)
            dhcm_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg[AW-1:0];
                mem_wdata = 64'd0;
                clr_cnt_next = clr_cnt_reg + TW'(1);
                if (clr_cnt_reg == TW'(TABLE_DEPTH - 1))
                begin
                    clr_cnt_next = '0;
                    clr_req_next = 1'b0;
                    state_next   = clr_req_reg ? dhcm_pkg::ST_RESULT : dhcm_pkg::ST_IDLE;
                end
            end

            dhcm_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    req_next    = s_tuser;
                    tuple_next  = s_tdata;
                    key_next    = s_tdata & key_mask_reg;
                    res_next    = '0;
                    shreg_next  = s_tdata & key_mask_reg;
                    rem_a_next  = '0;
                    rem_b_next  = '0;
                    bit_cnt_next = '0;
                    case (s_tuser)
                        dhcm_pkg::REQ_INSERT: state_next = dhcm_pkg::ST_HASH;
                        dhcm_pkg::REQ_QUERY:  state_next = dhcm_pkg::ST_HASH;
                        dhcm_pkg::REQ_FINISH: state_next = dhcm_pkg::ST_FIN_UNI;
                        default:
                        begin
                            clr_req_next = 1'b1;
                            ref_cnt_next = '0;
                            qry_cnt_next = '0;
                            shared_next  = '0;
                            differ_next  = '0;
                            state_next   = dhcm_pkg::ST_CLEAR;
                        end
                    endcase
                end
            end

            dhcm_pkg::ST_HASH:
            begin
                rem_a_next   = ra_new;
                rem_b_next   = rb_new;
                shreg_next   = {shreg_reg[62:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 6'd1;
                if (bit_cnt_reg == 6'd63)
                begin
                    idx_next       = ra_new;
                    step_next      = rb_new + TW'(1);
                    probe_cnt_next = '0;
                    state_next     = dhcm_pkg::ST_RD;
                end
            end

            dhcm_pkg::ST_RD:
            begin
                state_next = dhcm_pkg::ST_CHK;
            end

            dhcm_pkg::ST_CHK:
            begin
                if (req_reg == dhcm_pkg::REQ_INSERT)
                begin
                    if (slot_empty)
                    begin
                        mem_we       = 1'b1;
                        ref_cnt_next = sat_inc(ref_cnt_reg);
                        state_next   = dhcm_pkg::ST_RESULT;
                    end
                    else if (probe_cnt_reg == t_m1)
                    begin
                        res_next.table_full = 1'b1;
                        ref_cnt_next = sat_inc(ref_cnt_reg);
                        state_next   = dhcm_pkg::ST_RESULT;
                    end
                    else
                    begin
                        idx_next       = idx_wrap;
                        probe_cnt_next = probe_cnt_reg + TW'(1);
                        state_next     = dhcm_pkg::ST_RD;
                    end
                end
                else
                begin
                    if (slot_empty)
                    begin
                        qry_cnt_next = sat_inc(qry_cnt_reg);
                        state_next   = dhcm_pkg::ST_RESULT;
                    end
                    else if (slot_hit)
                    begin
                        res_next.matched        = 1'b1;
                        res_next.object_differs = (rd_data_reg != tuple_reg);
                        qry_cnt_next = sat_inc(qry_cnt_reg);
                        shared_next  = sat_inc(shared_reg);
                        if (rd_data_reg != tuple_reg)
                            differ_next = sat_inc(differ_reg);
                        state_next   = dhcm_pkg::ST_RESULT;
                    end
                    else if (probe_cnt_reg == t_m1)
                    begin
                        qry_cnt_next = sat_inc(qry_cnt_reg);
                        state_next   = dhcm_pkg::ST_RESULT;
                    end
                    else
                    begin
                        idx_next       = idx_wrap;
                        probe_cnt_next = probe_cnt_reg + TW'(1);
                        state_next     = dhcm_pkg::ST_RD;
                    end
                end
            end

            dhcm_pkg::ST_FIN_UNI:
            begin
                uni_next   = (both_sum > {1'b0, shared_reg}) ? both_sum - {1'b0, shared_reg}
                                                             : 33'd0;
                state_next = dhcm_pkg::ST_FIN_MUL;
            end

            dhcm_pkg::ST_FIN_MUL:
            begin
                prod_j_next  = 49'(jaccard_floor_reg) * 49'(uni_reg);
                prod_d_next  = 48'(max_distance_reg) * 48'(shared_reg);
                shreg_next   = {differ_reg, 32'd0};
                rem_d_next   = '0;
                bit_cnt_next = '0;
                state_next   = dhcm_pkg::ST_DIV;
            end

            dhcm_pkg::ST_DIV:
            begin
                rem_d_next   = rd_ge ? rd_diff[31:0] : rd_sh[31:0];
                shreg_next   = {shreg_reg[62:0], rd_ge};
                bit_cnt_next = bit_cnt_reg + 6'd1;
                if (bit_cnt_reg == 6'd47)
                    state_next = dhcm_pkg::ST_FIN_END;
            end

            dhcm_pkg::ST_FIN_END:
            begin
                if (test_shared && test_jaccard && test_dist && (shared_reg != 32'd0))
                begin
                    res_next.related      = 1'b1;
                    res_next.distance_q16 = (quotient > 48'hFFFF) ? 16'hFFFF
                                                                  : quotient[15:0];
                end
                else
                begin
                    res_next.distance_q16 = unrel_dist_reg;
                end
                state_next = dhcm_pkg::ST_RESULT;
            end

            dhcm_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next              = res_reg;
                    out_next.shared_count = shared_reg;
                    out_next.differ_count = differ_reg;
                    out_valid_next        = 1'b1;
                    // A finish opens a new query set once its counts are out.
                    if (req_reg == dhcm_pkg::REQ_FINISH)
                    begin
                        qry_cnt_next = '0;
                        shared_next  = '0;
                        differ_next  = '0;
                    end
                    state_next = dhcm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dhcm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dhcm_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            clr_req_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            ref_cnt_reg   <= '0;
            qry_cnt_reg   <= '0;
            shared_reg    <= '0;
            differ_reg    <= '0;
            bit_cnt_reg   <= '0;
            probe_cnt_reg <= '0;
            req_reg       <= dhcm_pkg::REQ_INSERT;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_req_reg   <= clr_req_next;
            out_valid_reg <= out_valid_next;
            ref_cnt_reg   <= ref_cnt_next;
            qry_cnt_reg   <= qry_cnt_next;
            shared_reg    <= shared_next;
            differ_reg    <= differ_next;
            bit_cnt_reg   <= bit_cnt_next;
            probe_cnt_reg <= probe_cnt_next;
            req_reg       <= req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        step_reg   <= step_next;
        rem_a_reg  <= rem_a_next;
        rem_b_reg  <= rem_b_next;
        rem_d_reg  <= rem_d_next;
        shreg_reg  <= shreg_next;
        tuple_reg  <= tuple_next;
        key_reg    <= key_next;
        uni_reg    <= uni_next;
        prod_j_reg <= prod_j_next;
        prod_d_reg <= prod_d_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg};

    `DHCM_ASSERT_IMP(a_probe_in_range, state_reg == dhcm_pkg::ST_RD, idx_reg < t_eff && probe_cnt_reg < t_eff && step_reg != '0, "probe index, count or step out of range")
    `DHCM_ASSERT_NEXT(a_result_handover, state_reg == dhcm_pkg::ST_RESULT && (!out_valid_reg || m_tready), m_tvalid && state_reg == dhcm_pkg::ST_IDLE, "result not handed to the output register")
    `DHCM_ASSERT_IMP(a_teff_range, 1'b1, t_eff >= TW'(2) && t_eff <= TW'(TABLE_DEPTH), "slots in use outside the table")
    `DHCM_ASSERT_IMP(a_no_write_when_idle, state_reg == dhcm_pkg::ST_IDLE, !mem_we, "slot memory written while idle")

endmodule
